@@ rtl/core/sisp_pkg.sv @@
// Shared types and constants for the skin influence slot packer.
// No dependencies; used by every file under rtl/core but sisp_ram.
`timescale 1ns / 1ps

package sisp_pkg;

    // Field widths of the item and result ports
    localparam int VID_W    = 12;
    localparam int BONE_W   = 8;
    localparam int WT_W     = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int SLOTS    = 4;
    localparam int SLOT_W   = 2;

    // One vertex entry: four bones in the low word, four weights above them
    localparam int BONES_W  = SLOTS * BONE_W;
    localparam int WTS_W    = SLOTS * WT_W;
    localparam int ENTRY_W  = BONES_W + WTS_W;

    // Store size default and bone index limit
    localparam int NUM_VERTICES_DEF = 4096;
    localparam int MAX_BONES        = 256;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READ    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;   // write zero at the sweep address, then step it
        logic load;     // capture the item and start the entry read
        logic exec;     // read data is back: modify, write, register result
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last; // sweep address is on the last entry
    } t_dp_status;

endpackage

@@ rtl/core/sisp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sisp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/sisp_ctrl.sv @@
// Controller for the slot packer: clearing sweep, idle, read-modify-write.
// Depends on sisp_pkg.
`timescale 1ns / 1ps

module sisp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  sisp_pkg::t_dp_status  i_dp_status,
    output sisp_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_busy
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_dp_status.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_start) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // State and registered busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    // Commands
    assign o_cmd.clr_wr = (r_state == S_CLEAR);
    assign o_cmd.load   = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_busy       = r_busy;

endmodule

@@ rtl/core/sisp_datapath.sv @@
// Datapath for the slot packer: item registers, slot search, entry store, result registers.
// Depends on sisp_pkg and sisp_ram.
`timescale 1ns / 1ps

module sisp_datapath #(
    parameter int NUM_VERTICES = sisp_pkg::NUM_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sisp_pkg::t_ctrl_cmd             i_cmd,
    output sisp_pkg::t_dp_status            o_dp_status,
    input  logic [sisp_pkg::OP_W-1:0]       i_opcode,
    input  logic [sisp_pkg::VID_W-1:0]      i_vertex_id,
    input  logic [sisp_pkg::BONE_W-1:0]     i_bone_id,
    input  logic [sisp_pkg::WT_W-1:0]       i_influence_weight,
    output logic                            o_result_valid,
    output logic [sisp_pkg::STATUS_W-1:0]   o_status,
    output logic [sisp_pkg::SLOT_W-1:0]     o_slot_used,
    output logic [sisp_pkg::BONES_W-1:0]    o_bones,
    output logic [sisp_pkg::WTS_W-1:0]      o_weights
);

    localparam int AW = $clog2(NUM_VERTICES);

    // Item registers
    logic [sisp_pkg::OP_W-1:0]    r_op;
    logic [AW-1:0]                r_addr;
    logic                         r_vid_ok;
    logic                         r_bone_ok;
    logic [sisp_pkg::BONE_W-1:0]  r_bone;
    logic [sisp_pkg::WT_W-1:0]    r_wt;

    // Clearing sweep address
    logic [AW-1:0]                r_clr_addr;

    // Store interface
    logic [sisp_pkg::ENTRY_W-1:0] rd_entry;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [sisp_pkg::ENTRY_W-1:0] ram_wdata;

    // Item decode
    logic [31:0]                  vid_ext;

    // Modify results
    logic [sisp_pkg::ENTRY_W-1:0] n_entry;
    logic                         n_wr;
    logic [sisp_pkg::STATUS_W-1:0] n_status;
    logic [sisp_pkg::SLOT_W-1:0]  n_slot_used;
    logic [sisp_pkg::BONES_W-1:0] n_bones;
    logic [sisp_pkg::WTS_W-1:0]   n_weights;

    // Result registers
    logic                         r_result_valid;
    logic [sisp_pkg::STATUS_W-1:0] r_status;
    logic [sisp_pkg::SLOT_W-1:0]  r_slot_used;
    logic [sisp_pkg::BONES_W-1:0] r_bones;
    logic [sisp_pkg::WTS_W-1:0]   r_weights;

    assign vid_ext = 32'(i_vertex_id);

    // Capture the item on load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_opcode;
            r_addr    <= vid_ext[AW-1:0];
            r_vid_ok  <= (vid_ext < 32'(NUM_VERTICES));
            r_bone_ok <= (32'(i_bone_id) < 32'(sisp_pkg::MAX_BONES));
            r_bone    <= i_bone_id;
            r_wt      <= i_influence_weight;
        end
    end

    // Sweep address after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_dp_status.clr_last = (r_clr_addr == AW'(NUM_VERTICES - 1));

    // Slot search and entry update
    always_comb begin
        logic found;
        found       = 1'b0;
        n_entry     = rd_entry;
        n_wr        = 1'b0;
        n_status    = sisp_pkg::ST_READ;
        n_slot_used = '0;
        n_bones     = '0;
        n_weights   = '0;
        case (r_op)
            sisp_pkg::OP_ADD: begin
                n_status = sisp_pkg::ST_DROPPED;
                if (r_vid_ok && r_bone_ok) begin
                    // first slot with a zero weight takes the influence
                    for (int k = 0; k < sisp_pkg::SLOTS; k++) begin
                        if (!found &&
                            rd_entry[sisp_pkg::BONES_W + k*sisp_pkg::WT_W +: sisp_pkg::WT_W]
                                == '0) begin
                            found = 1'b1;
                            n_entry[k*sisp_pkg::BONE_W +: sisp_pkg::BONE_W] = r_bone;
                            n_entry[sisp_pkg::BONES_W + k*sisp_pkg::WT_W +: sisp_pkg::WT_W]
                                = r_wt;
                            n_slot_used = sisp_pkg::SLOT_W'(k);
                        end
                    end
                    if (found) begin
                        n_wr     = 1'b1;
                        n_status = sisp_pkg::ST_STORED;
                    end
                end
            end
            sisp_pkg::OP_CLEAR: begin
                n_status = sisp_pkg::ST_CLEARED;
                n_entry  = '0;
                n_wr     = r_vid_ok;
            end
            default: begin
                // read, and the unused code taken as a read
                if (r_vid_ok) begin
                    n_bones   = rd_entry[sisp_pkg::BONES_W-1:0];
                    n_weights = rd_entry[sisp_pkg::ENTRY_W-1:sisp_pkg::BONES_W];
                end
            end
        endcase
    end

    // Write port: sweep zeroes, otherwise the modified entry
    assign ram_we    = i_cmd.clr_wr || (i_cmd.exec && n_wr);
    assign ram_waddr = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign ram_wdata = i_cmd.clr_wr ? '0 : n_entry;

    sisp_ram #(
        .WIDTH (sisp_pkg::ENTRY_W),
        .DEPTH (NUM_VERTICES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr (vid_ext[AW-1:0]),
        .o_rd_data (rd_entry)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.exec;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_slot_used <= n_slot_used;
            r_bones     <= n_bones;
            r_weights   <= n_weights;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_status       = r_status;
    assign o_slot_used    = r_slot_used;
    assign o_bones        = r_bones;
    assign o_weights      = r_weights;

endmodule

@@ rtl/core/skin_influence_slot_packer_unit.sv @@
// Top level of the skin influence slot packer: per-vertex four-slot bone/weight store.
// Depends on sisp_pkg, sisp_ctrl, sisp_datapath (and sisp_ram below it).
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+------------------------------------------
//  item in  | start high while busy low    | i_opcode, i_vertex_id, i_bone_id,
//           |                              | i_influence_weight
//  result   | o_result_valid, one cycle    | o_status, o_slot_used, o_bone_a..d,
//           |                              | o_weight_a..d
//
// An accepted item is captured and its entry read; in EXEC the entry is modified and
// written back and the result registered, raising the result strobe. Busy is high
// for a single cycle meanwhile, so no new item is taken before the last result is
// registered: each item is one read-modify-write of the entry RAM (registered read).
// After reset all NUM_VERTICES entries are swept to zero, one entry a cycle, with
// busy high throughout. Results cannot be held off and are never held back.
`timescale 1ns / 1ps

module skin_influence_slot_packer_unit #(
    parameter int NUM_VERTICES = sisp_pkg::NUM_VERTICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sisp_pkg::OP_W-1:0]     i_opcode,
    input  logic [sisp_pkg::VID_W-1:0]    i_vertex_id,
    input  logic [sisp_pkg::BONE_W-1:0]   i_bone_id,
    input  logic [sisp_pkg::WT_W-1:0]     i_influence_weight,
    output logic                          o_result_valid,
    output logic [sisp_pkg::STATUS_W-1:0] o_status,
    output logic [sisp_pkg::SLOT_W-1:0]   o_slot_used,
    output logic [sisp_pkg::BONE_W-1:0]   o_bone_a,
    output logic [sisp_pkg::BONE_W-1:0]   o_bone_b,
    output logic [sisp_pkg::BONE_W-1:0]   o_bone_c,
    output logic [sisp_pkg::BONE_W-1:0]   o_bone_d,
    output logic [sisp_pkg::WT_W-1:0]     o_weight_a,
    output logic [sisp_pkg::WT_W-1:0]     o_weight_b,
    output logic [sisp_pkg::WT_W-1:0]     o_weight_c,
    output logic [sisp_pkg::WT_W-1:0]     o_weight_d
);

    localparam int BW = sisp_pkg::BONE_W;
    localparam int WW = sisp_pkg::WT_W;

    sisp_pkg::t_ctrl_cmd          cmd;
    sisp_pkg::t_dp_status         dp_status;
    logic [sisp_pkg::BONES_W-1:0] bones;
    logic [sisp_pkg::WTS_W-1:0]   weights;

    sisp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_dp_status (dp_status),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    sisp_datapath #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_dp_status        (dp_status),
        .i_opcode           (i_opcode),
        .i_vertex_id        (i_vertex_id),
        .i_bone_id          (i_bone_id),
        .i_influence_weight (i_influence_weight),
        .o_result_valid     (o_result_valid),
        .o_status           (o_status),
        .o_slot_used        (o_slot_used),
        .o_bones            (bones),
        .o_weights          (weights)
    );

    // Unpack slots onto their ports
    assign o_bone_a   = bones[0*BW +: BW];
    assign o_bone_b   = bones[1*BW +: BW];
    assign o_bone_c   = bones[2*BW +: BW];
    assign o_bone_d   = bones[3*BW +: BW];
    assign o_weight_a = weights[0*WW +: WW];
    assign o_weight_b = weights[1*WW +: WW];
    assign o_weight_c = weights[2*WW +: WW];
    assign o_weight_d = weights[3*WW +: WW];

endmodule

@@ tb/tb_skin_influence_slot_packer_unit.sv @@
// Self-checking testbench for skin_influence_slot_packer_unit: per-vertex four-slot store.
// Depends on sisp_pkg and the RTL under rtl/core; a local model predicts every result.
`timescale 1ns / 1ps

module tb_skin_influence_slot_packer_unit;

    localparam int VERTEX_COUNT = sisp_pkg::NUM_VERTICES_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_SIZE    = 6;
    localparam int OP_W     = sisp_pkg::OP_W;
    localparam int VID_W    = sisp_pkg::VID_W;
    localparam int BONE_W   = sisp_pkg::BONE_W;
    localparam int WT_W     = sisp_pkg::WT_W;
    localparam int STATUS_W = sisp_pkg::STATUS_W;
    localparam int SLOT_W   = sisp_pkg::SLOT_W;
    localparam int BONES_W  = sisp_pkg::BONES_W;
    localparam int WTS_W    = sisp_pkg::WTS_W;
    // Opcode 3 has no function of its own and behaves as a read
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // One item as driven on the input ports
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VID_W-1:0]  vid;
        logic [BONE_W-1:0] bone;
        logic [WT_W-1:0]   weight;
    } t_vertex_cmd;

    // One expected result, slot k bone and weight at lane k
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [BONES_W-1:0]  bones;
        logic [WTS_W-1:0]    weights;
    } t_slot_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_W-1:0]   i_opcode = '0;
    logic [VID_W-1:0]  i_vertex_id = '0;
    logic [BONE_W-1:0] i_bone_id = '0;
    logic [WT_W-1:0]   i_influence_weight = '0;
    logic                o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_used;
    logic [BONE_W-1:0]   o_bone_a, o_bone_b, o_bone_c, o_bone_d;
    logic [WT_W-1:0]     o_weight_a, o_weight_b, o_weight_c, o_weight_d;

    // Model copy of the vertex store, zero from the start like the swept RAM
    bit [BONES_W-1:0] model_bones [VERTEX_COUNT];
    bit [WTS_W-1:0]   model_weights [VERTEX_COUNT];

    t_slot_result pending_results[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           no_gaps = 1'b0;
    logic [VID_W-1:0] vertex_pool [POOL_SIZE];

    skin_influence_slot_packer_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_vertex_id        (i_vertex_id),
        .i_bone_id          (i_bone_id),
        .i_influence_weight (i_influence_weight),
        .o_result_valid     (o_result_valid),
        .o_status           (o_status),
        .o_slot_used        (o_slot_used),
        .o_bone_a           (o_bone_a),
        .o_bone_b           (o_bone_b),
        .o_bone_c           (o_bone_c),
        .o_bone_d           (o_bone_d),
        .o_weight_a         (o_weight_a),
        .o_weight_b         (o_weight_b),
        .o_weight_c         (o_weight_c),
        .o_weight_d         (o_weight_d)
    );

    always #1 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_vertex_cmd make_cmd(logic [OP_W-1:0] op, logic [VID_W-1:0] vid,
                                             logic [BONE_W-1:0] bone, logic [WT_W-1:0] wt);
        t_vertex_cmd cmd;
        cmd.op     = op;
        cmd.vid    = vid;
        cmd.bone   = bone;
        cmd.weight = wt;
        return cmd;
    endfunction

    // Apply one item to the model store and return the result it gives
    function automatic t_slot_result apply_vertex_cmd(t_vertex_cmd cmd);
        t_slot_result res;
        bit           vid_ok;
        bit           placed;
        res    = '0;
        vid_ok = int'(cmd.vid) < VERTEX_COUNT;
        placed = 1'b0;
        case (cmd.op)
            sisp_pkg::OP_ADD: begin
                res.status = sisp_pkg::ST_DROPPED;
                if (vid_ok && int'(cmd.bone) < sisp_pkg::MAX_BONES) begin
                    // first slot with zero weight takes the influence
                    for (int k = 0; k < sisp_pkg::SLOTS; k++) begin
                        if (!placed && model_weights[cmd.vid][k*WT_W +: WT_W] == '0) begin
                            model_bones[cmd.vid][k*BONE_W +: BONE_W] = cmd.bone;
                            model_weights[cmd.vid][k*WT_W +: WT_W]   = cmd.weight;
                            res.status = sisp_pkg::ST_STORED;
                            res.slot   = SLOT_W'(k);
                            placed     = 1'b1;
                        end
                    end
                end
            end
            sisp_pkg::OP_CLEAR: begin
                res.status = sisp_pkg::ST_CLEARED;
                if (vid_ok) begin
                    model_bones[cmd.vid]   = '0;
                    model_weights[cmd.vid] = '0;
                end
            end
            default: begin
                res.status = sisp_pkg::ST_READ;
                if (vid_ok) begin
                    res.bones   = model_bones[cmd.vid];
                    res.weights = model_weights[cmd.vid];
                end
            end
        endcase
        return res;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("ERROR %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // Result checker: outputs are read before this edge's updates land
    always @(posedge i_clk) begin : result_check
        t_slot_result want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR unexpected result, status %0h", o_status);
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 64'(want.status), 64'(o_status));
                compare_field("slot_used", 64'(want.slot), 64'(o_slot_used));
                compare_field("bone_a", 64'(want.bones[0*BONE_W +: BONE_W]), 64'(o_bone_a));
                compare_field("bone_b", 64'(want.bones[1*BONE_W +: BONE_W]), 64'(o_bone_b));
                compare_field("bone_c", 64'(want.bones[2*BONE_W +: BONE_W]), 64'(o_bone_c));
                compare_field("bone_d", 64'(want.bones[3*BONE_W +: BONE_W]), 64'(o_bone_d));
                compare_field("weight_a", 64'(want.weights[0*WT_W +: WT_W]), 64'(o_weight_a));
                compare_field("weight_b", 64'(want.weights[1*WT_W +: WT_W]), 64'(o_weight_b));
                compare_field("weight_c", 64'(want.weights[2*WT_W +: WT_W]), 64'(o_weight_c));
                compare_field("weight_d", 64'(want.weights[3*WT_W +: WT_W]), 64'(o_weight_d));
            end
        end
    end

    // Send one item after a random gap; start stays high when there is no gap
    task automatic send_item(input t_vertex_cmd cmd);
        int           gap;
        t_slot_result res;
        gap = no_gaps ? 0 : $urandom_range(16, 0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_opcode           <= cmd.op;
        i_vertex_id        <= cmd.vid;
        i_bone_id          <= cmd.bone;
        i_influence_weight <= cmd.weight;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        res             = apply_vertex_cmd(cmd);
        pending_results = {pending_results, res};
    endtask

    // Hold the sender off until every expected result has come back
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [WT_W-1:0] draw_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            3:       return WT_W'($urandom);
            default: return WT_W'($urandom_range(32768, 1));
        endcase
    endfunction

    // Read one vertex empty, fill it, overflow it, read back, clear, read again
    task automatic test_slot_fill_and_drop();
        logic [VID_W-1:0] vid;
        vid = 12'h0A5;
        send_item(make_cmd(sisp_pkg::OP_READ, vid, 8'h00, 16'h0000));
        send_item(make_cmd(sisp_pkg::OP_ADD, vid, 8'h00, 16'd32768));
        send_item(make_cmd(sisp_pkg::OP_ADD, vid, 8'hFF, 16'h0001));
        send_item(make_cmd(sisp_pkg::OP_ADD, vid, 8'h5A, 16'hFFFF));
        send_item(make_cmd(sisp_pkg::OP_ADD, vid, 8'hA5, 16'h7FFF));
        send_item(make_cmd(sisp_pkg::OP_ADD, vid, 8'h01, 16'h0002));
        send_item(make_cmd(sisp_pkg::OP_READ, vid, 8'hFF, 16'hFFFF));
        send_item(make_cmd(sisp_pkg::OP_CLEAR, vid, 8'hFF, 16'hFFFF));
        send_item(make_cmd(sisp_pkg::OP_READ, vid, 8'h00, 16'h0000));
    endtask

    // A stored zero weight leaves its slot free for the next add
    task automatic test_zero_weight_reuse();
        logic [VID_W-1:0] vid;
        vid = 12'h5A0;
        send_item(make_cmd(sisp_pkg::OP_ADD, vid, 8'h11, 16'h0000));
        send_item(make_cmd(sisp_pkg::OP_READ, vid, 8'h00, 16'h0000));
        wait_results_drained();
        send_item(make_cmd(sisp_pkg::OP_ADD, vid, 8'h22, 16'd100));
        send_item(make_cmd(sisp_pkg::OP_READ, vid, 8'h00, 16'h0000));
    endtask

    // Lowest and highest vertex, and the spare opcode as a read
    task automatic test_edge_vertices();
        send_item(make_cmd(sisp_pkg::OP_ADD, 12'h000, 8'h03, 16'd8000));
        send_item(make_cmd(sisp_pkg::OP_ADD, 12'hFFF, 8'hC8, 16'd32768));
        send_item(make_cmd(OP_SPARE, 12'hFFF, 8'hFF, 16'hFFFF));
        send_item(make_cmd(sisp_pkg::OP_READ, 12'h000, 8'h00, 16'h0000));
        send_item(make_cmd(sisp_pkg::OP_CLEAR, 12'hFFF, 8'h00, 16'h0000));
        send_item(make_cmd(sisp_pkg::OP_READ, 12'hFFF, 8'h00, 16'h0000));
    endtask

    // Add/read/clear traffic on a few hot vertices so slots fill, overflow and recycle
    task automatic test_random_vertex_traffic(input int count);
        t_vertex_cmd cmd;
        int          pick;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0)
                no_gaps = ($urandom_range(3) == 0);
            if ($urandom_range(31) == 0)
                vertex_pool[$urandom_range(POOL_SIZE-1)] = VID_W'($urandom);
            cmd.vid    = vertex_pool[$urandom_range(POOL_SIZE-1)];
            cmd.bone   = BONE_W'($urandom);
            cmd.weight = draw_weight();
            pick       = $urandom_range(99);
            if (pick < 50)
                cmd.op = sisp_pkg::OP_ADD;
            else if (pick < 75)
                cmd.op = sisp_pkg::OP_READ;
            else if (pick < 90)
                cmd.op = sisp_pkg::OP_CLEAR;
            else if (pick < 95)
                cmd.op = OP_SPARE;
            else begin
                cmd.op  = $urandom_range(1) ? sisp_pkg::OP_ADD : sisp_pkg::OP_READ;
                cmd.vid = VID_W'($urandom);
            end
            send_item(cmd);
            if (n == count / 2)
                wait_results_drained();
        end
    endtask

    // Fully random fields over the whole store
    task automatic test_random_noise(input int count);
        t_vertex_cmd cmd;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0)
                no_gaps = ($urandom_range(3) == 0);
            cmd.op     = OP_W'($urandom);
            cmd.vid    = VID_W'($urandom);
            cmd.bone   = BONE_W'($urandom);
            cmd.weight = WT_W'($urandom);
            send_item(cmd);
        end
    endtask

    initial begin
        for (int p = 0; p < POOL_SIZE; p++)
            vertex_pool[p] = VID_W'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_slot_fill_and_drop();
        test_zero_weight_reuse();
        test_edge_vertices();
        test_random_vertex_traffic(1400);
        test_random_noise(280);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sisp_pkg.sv
rtl/core/sisp_ram.sv
rtl/core/sisp_ctrl.sv
rtl/core/sisp_datapath.sv
rtl/core/skin_influence_slot_packer_unit.sv
tb/tb_skin_influence_slot_packer_unit.sv
